[rtl/core/variable_partition_allocator_core_macros.svh]
// Assertion macros shared by the allocator RTL.
`ifndef VARIABLE_PARTITION_ALLOCATOR_CORE_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked on every clock edge out of reset.
`define VPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen out of reset.
`define VPA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define VPA_ASSERT(lbl, prop, msg)
`define VPA_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[rtl/core/vpa_pkg.sv]
// Codes, port widths and parameter defaults of the partition allocator.
package vpa_pkg;
  localparam int MEM_WORDS_DEF = 512;
  localparam int MAX_PARTS_DEF = 64;
  localparam int JOB_BITS_DEF  = 16;

  localparam int IN_JOB_W  = 16;
  localparam int REQ_W     = 10;
  localparam int START_O_W = 9;
  localparam int STATUS_W  = 2;
  localparam int POL_W     = 2;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NOFIT = 2'd1;
  localparam status_t ST_NOJOB = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  typedef logic [POL_W-1:0] policy_t;
  localparam policy_t POL_FIRST = 2'd0;
  localparam policy_t POL_BEST  = 2'd1;
  localparam policy_t POL_WORST = 2'd2;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
endpackage

[rtl/core/variable_partition_allocator_core.sv]
// Variable partition allocator: partition table in one memory, sequenced per transaction.
`include "variable_partition_allocator_core_macros.svh"

// The block keeps an address-ordered table of contiguous partitions covering
// MEM_WORDS units, one entry per memory word (start, size, busy, owner), and
// serves one transaction at a time. An allocate scans the table once, and on
// a split shifts the entries above the chosen one up by one before writing the
// two halves; a release streams the table once, rewriting it compacted with
// merged free runs. After reset the S_INIT state writes the initial entry
// before the first transaction is taken. The finished result sits in an output
// register, so a new transaction is taken while the result still waits to be
// collected. The user must write fit_policy only while the block is idle; the
// block itself does not enforce this. A value of three acts as first fit.
module variable_partition_allocator_core #(
  parameter int MEM_WORDS = vpa_pkg::MEM_WORDS_DEF,
  parameter int MAX_PARTS = vpa_pkg::MAX_PARTS_DEF,
  parameter int JOB_BITS  = vpa_pkg::JOB_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vpa_pkg::POL_W-1:0]      cfg_fit_policy,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [vpa_pkg::IN_JOB_W-1:0]   in_job_id,
  input  logic [vpa_pkg::REQ_W-1:0]      in_req_size,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [vpa_pkg::STATUS_W-1:0]   out_status,
  output logic [vpa_pkg::START_O_W-1:0]  out_alloc_start
);
  localparam int AW   = $clog2(MEM_WORDS);
  localparam int SW   = $clog2(MEM_WORDS + 1);
  localparam int CW   = (SW > vpa_pkg::REQ_W) ? SW : vpa_pkg::REQ_W;
  localparam int IDXW = $clog2(MAX_PARTS);
  localparam int CNTW = $clog2(MAX_PARTS + 1);
  localparam int EW   = JOB_BITS + 1 + SW + AW;
  localparam int OW   = (AW > vpa_pkg::START_O_W) ? AW : vpa_pkg::START_O_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_SPLIT, S_PICK,
    S_REL, S_REL_END, S_OUT
  } state_t;

  state_t                  state_r;
  logic [EW-1:0]           mem [MAX_PARTS];
  logic [EW-1:0]           rdata_r;
  logic                    mem_we;
  logic [IDXW-1:0]         mem_waddr;
  logic [EW-1:0]           mem_wdata;

  logic [vpa_pkg::POL_W-1:0] policy_r;
  logic                    op_r;
  logic [JOB_BITS-1:0]     job_r;
  logic [vpa_pkg::REQ_W-1:0] req_r;
  logic [CNTW-1:0]         count_r;
  logic [CNTW-1:0]         rd_idx_r;
  logic [CNTW-1:0]         wr_idx_r;
  logic [IDXW-1:0]         proc_idx_r;
  logic                    rv_r;
  logic                    found_r;
  logic [IDXW-1:0]         pick_r;
  logic [AW-1:0]           pick_start_r;
  logic [SW-1:0]           pick_size_r;
  logic [AW-1:0]           pend_start_r;
  logic [SW-1:0]           pend_size_r;
  logic                    pend_busy_r;
  logic [JOB_BITS-1:0]     pend_owner_r;
  logic                    out_valid_r;
  logic [vpa_pkg::STATUS_W-1:0] res_status_r;
  logic [AW-1:0]           res_start_r;
  logic [vpa_pkg::STATUS_W-1:0] out_status_r;
  logic [vpa_pkg::START_O_W-1:0] out_start_r;

  logic [JOB_BITS+vpa_pkg::IN_JOB_W-1:0] job_ext;
  logic [AW-1:0]           e_start;
  logic [SW-1:0]           e_size;
  logic                    e_busy;
  logic [JOB_BITS-1:0]     e_owner;
  logic                    e_match;
  logic                    e_busy_new;
  logic                    e_fits;
  logic                    issue_up;
  logic                    issue_dn;
  logic                    flush;
  logic [CNTW-1:0]         pick_ext;
  logic [CW:0]             split_start_sum;
  logic [OW-1:0]           start_wide;

  assign job_ext    = {{JOB_BITS{1'b0}}, in_job_id};
  assign e_start    = rdata_r[AW-1:0];
  assign e_size     = rdata_r[AW+SW-1:AW];
  assign e_busy     = rdata_r[AW+SW];
  assign e_owner    = rdata_r[EW-1:AW+SW+1];
  assign e_match    = e_busy && (e_owner == job_r);
  assign e_busy_new = e_busy && !e_match;
  assign e_fits     = !e_busy && (CW'(e_size) >= CW'(req_r));
  assign issue_up   = rd_idx_r < count_r;
  assign pick_ext   = CNTW'(pick_r);
  assign issue_dn   = rd_idx_r > pick_ext;
  // Close the pending entry unless two free entries meet.
  assign flush      = rv_r && (proc_idx_r != '0) && !(!pend_busy_r && !e_busy_new);
  assign split_start_sum = (CW+1)'(pick_start_r) + (CW+1)'(req_r);
  assign start_wide = OW'(res_start_r);

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_alloc_start = out_start_r;

  // Table write port: at most one write per cycle, chosen by the sequencer state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {{JOB_BITS{1'b0}}, 1'b0, SW'(MEM_WORDS), {AW{1'b0}}};
      end
      S_SHIFT: begin
        mem_we    = rv_r;
        mem_waddr = IDXW'(CNTW'(proc_idx_r) + CNTW'(1));
        mem_wdata = rdata_r;
      end
      S_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = IDXW'(pick_ext + CNTW'(1));
        mem_wdata = {{JOB_BITS{1'b0}}, 1'b0, SW'(pick_size_r - SW'(req_r)),
                     AW'(split_start_sum)};
      end
      S_PICK: begin
        mem_we    = 1'b1;
        mem_waddr = pick_r;
        mem_wdata = {job_r, 1'b1, SW'(req_r), pick_start_r};
      end
      S_REL: begin
        mem_we    = flush;
        mem_waddr = wr_idx_r[IDXW-1:0];
        mem_wdata = {pend_owner_r, pend_busy_r, pend_size_r, pend_start_r};
      end
      S_REL_END: begin
        mem_we    = 1'b1;
        mem_waddr = wr_idx_r[IDXW-1:0];
        mem_wdata = {pend_owner_r, pend_busy_r, pend_size_r, pend_start_r};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Partition table: synchronous memory, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_idx_r[IDXW-1:0]];
  end

  // Sequencer: state, counters and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CNTW'(1);
      policy_r    <= vpa_pkg::POL_FIRST;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy_r <= cfg_fit_policy;
      end
      // Drop a collected result unless a new one is loaded this cycle.
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r        <= in_op;
            job_r       <= job_ext[JOB_BITS-1:0];
            req_r       <= in_req_size;
            rd_idx_r    <= '0;
            wr_idx_r    <= '0;
            rv_r        <= 1'b0;
            found_r     <= 1'b0;
            res_start_r <= '0;
            if (in_op == vpa_pkg::OP_RELEASE) begin
              state_r <= S_REL;
            end else if (in_req_size == '0) begin
              res_status_r <= vpa_pkg::ST_NOFIT;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rv_r       <= issue_up;
          proc_idx_r <= rd_idx_r[IDXW-1:0];
          if (issue_up) begin
            rd_idx_r <= rd_idx_r + CNTW'(1);
          end
          if (rv_r && e_fits) begin
            found_r <= 1'b1;
            if (!found_r ||
                (policy_r == vpa_pkg::POL_BEST && e_size < pick_size_r) ||
                (policy_r == vpa_pkg::POL_WORST && e_size >= pick_size_r)) begin
              pick_r       <= proc_idx_r;
              pick_start_r <= e_start;
              pick_size_r  <= e_size;
            end
          end
          if (!issue_up && !rv_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!found_r) begin
            res_status_r <= vpa_pkg::ST_NOFIT;
            state_r      <= S_OUT;
          end else if (CW'(pick_size_r) > CW'(req_r)) begin
            if (count_r == CNTW'(MAX_PARTS)) begin
              res_status_r <= vpa_pkg::ST_FULL;
              state_r      <= S_OUT;
            end else begin
              rd_idx_r <= count_r - CNTW'(1);
              rv_r     <= 1'b0;
              state_r  <= S_SHIFT;
            end
          end else begin
            state_r <= S_PICK;
          end
        end
        S_SHIFT: begin
          // Move entries above the pick up by one, top first.
          rv_r       <= issue_dn;
          proc_idx_r <= rd_idx_r[IDXW-1:0];
          if (issue_dn) begin
            rd_idx_r <= rd_idx_r - CNTW'(1);
          end
          if (!issue_dn && !rv_r) begin
            state_r <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          count_r <= count_r + CNTW'(1);
          state_r <= S_PICK;
        end
        S_PICK: begin
          res_status_r <= vpa_pkg::ST_OK;
          res_start_r  <= pick_start_r;
          state_r      <= S_OUT;
        end
        S_REL: begin
          rv_r       <= issue_up;
          proc_idx_r <= rd_idx_r[IDXW-1:0];
          if (issue_up) begin
            rd_idx_r <= rd_idx_r + CNTW'(1);
          end
          if (rv_r) begin
            if (e_match) begin
              found_r <= 1'b1;
            end
            if (proc_idx_r == '0 || flush) begin
              pend_start_r <= e_start;
              pend_size_r  <= e_size;
              pend_busy_r  <= e_busy_new;
              pend_owner_r <= e_owner;
            end else begin
              pend_size_r <= pend_size_r + e_size;
            end
            if (flush) begin
              wr_idx_r <= wr_idx_r + CNTW'(1);
            end
          end
          if (!issue_up && !rv_r) begin
            state_r <= S_REL_END;
          end
        end
        S_REL_END: begin
          count_r      <= wr_idx_r + CNTW'(1);
          res_status_r <= found_r ? vpa_pkg::ST_OK : vpa_pkg::ST_NOJOB;
          state_r      <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free.
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_start_r  <= (res_status_r == vpa_pkg::ST_OK && op_r == vpa_pkg::OP_ALLOC)
                            ? start_wide[vpa_pkg::START_O_W-1:0] : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `VPA_ASSERT(a_count_range, (count_r != '0 && count_r <= CNTW'(MAX_PARTS)), "count range")
  `VPA_ASSERT(a_shift_above_pick, (state_r == S_SHIFT && mem_we) |-> (mem_waddr > pick_r), "shift")
  `VPA_ASSERT(a_rel_behind, (state_r == S_REL && mem_we) |-> (mem_waddr < proc_idx_r), "release")
  `VPA_ASSERT(a_out_from_out, $rose(out_valid_r) |-> ($past(state_r) == S_OUT), "result source")
  `VPA_ASSERT_NEVER(a_full_split, state_r == S_SPLIT && count_r == CNTW'(MAX_PARTS), "full split")
endmodule

[verif/vpa_checker.sv]
// Checker for the partition allocator: models the partition table and compares each result.
module vpa_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vpa_pkg::POL_W-1:0]     cfg_fit_policy,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_op,
  input  logic [vpa_pkg::IN_JOB_W-1:0]  in_job_id,
  input  logic [vpa_pkg::REQ_W-1:0]     in_req_size,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [vpa_pkg::STATUS_W-1:0]  out_status,
  input  logic [vpa_pkg::START_O_W-1:0] out_alloc_start,
  input  logic                          end_check,
  output int                            fail_count,
  output int                            checked,
  output int                            full_hits
);
  localparam int NPART = vpa_pkg::MAX_PARTS_DEF;

  // shadow partition table
  logic [8:0]  tbl_start [NPART];
  logic [9:0]  tbl_size  [NPART];
  bit          tbl_busy  [NPART];
  logic [15:0] tbl_owner [NPART];
  int          tbl_count;
  vpa_pkg::policy_t policy;

  vpa_pkg::status_t                     want_status_q [$];
  logic [vpa_pkg::START_O_W-1:0]        want_start_q  [$];

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void drop_entry(input int idx);
    for (int k = idx; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_size[k]  = tbl_size[k+1];
      tbl_busy[k]  = tbl_busy[k+1];
      tbl_owner[k] = tbl_owner[k+1];
    end
    tbl_count--;
  endfunction

  function automatic vpa_pkg::status_t place_job(input logic [15:0] job, input int req,
                                                 output logic [8:0] base);
    bit found;
    int pick;
    found = 0;
    pick = 0;
    base = '0;
    if (req == 0) return vpa_pkg::ST_NOFIT;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_busy[i] || tbl_size[i] < req) continue;
      if (!found) begin
        found = 1;
        pick = i;
        if (policy != vpa_pkg::POL_BEST && policy != vpa_pkg::POL_WORST) break;
      end else if (policy == vpa_pkg::POL_BEST) begin
        if (tbl_size[i] < tbl_size[pick]) pick = i;
      end else if (policy == vpa_pkg::POL_WORST) begin
        if (tbl_size[i] >= tbl_size[pick]) pick = i;
      end
    end
    if (!found) return vpa_pkg::ST_NOFIT;
    if (tbl_size[pick] > req) begin
      if (tbl_count >= NPART) return vpa_pkg::ST_FULL;
      for (int k = tbl_count; k > pick + 1; k--) begin
        tbl_start[k] = tbl_start[k-1];
        tbl_size[k]  = tbl_size[k-1];
        tbl_busy[k]  = tbl_busy[k-1];
        tbl_owner[k] = tbl_owner[k-1];
      end
      tbl_start[pick+1] = 9'(int'(tbl_start[pick]) + req);
      tbl_size[pick+1]  = 10'(int'(tbl_size[pick]) - req);
      tbl_busy[pick+1]  = 0;
      tbl_owner[pick+1] = '0;
      tbl_count++;
      tbl_size[pick] = 10'(req);
    end
    tbl_busy[pick]  = 1;
    tbl_owner[pick] = job;
    base = tbl_start[pick];
    return vpa_pkg::ST_OK;
  endfunction

  function automatic vpa_pkg::status_t free_job(input logic [15:0] job);
    bit found;
    int i;
    found = 0;
    i = 0;
    while (i < tbl_count) begin
      if (tbl_busy[i] && tbl_owner[i] == job) begin
        found = 1;
        tbl_busy[i]  = 0;
        tbl_owner[i] = '0;
        if (i + 1 < tbl_count && !tbl_busy[i+1]) begin
          tbl_size[i] = tbl_size[i] + tbl_size[i+1];
          drop_entry(i + 1);
        end
        if (i > 0 && !tbl_busy[i-1]) begin
          tbl_size[i-1] = tbl_size[i-1] + tbl_size[i];
          drop_entry(i);
          i--;
        end
      end
      i++;
    end
    return found ? vpa_pkg::ST_OK : vpa_pkg::ST_NOJOB;
  endfunction

  initial begin
    fail_count = 0;
    checked = 0;
    full_hits = 0;
  end

  always @(posedge clk) begin
    vpa_pkg::status_t st;
    logic [8:0] base;
    if (!rst_n) begin
      tbl_start[0] = '0;
      tbl_size[0]  = 10'(vpa_pkg::MEM_WORDS_DEF);
      for (int k = 0; k < NPART; k++) tbl_busy[k] = 0;
      tbl_count = 1;
      policy = vpa_pkg::POL_FIRST;
      want_status_q.delete();
      want_start_q.delete();
    end else begin
      if (cfg_we) policy = cfg_fit_policy;
      if (out_valid && !out_stall) begin
        checked++;
        if (want_status_q.size() == 0) begin
          report($sformatf("unexpected result status=%0d start=%0d",
                           out_status, out_alloc_start));
        end else begin
          if (out_status !== want_status_q[0])
            report($sformatf("status got %0d want %0d", out_status, want_status_q[0]));
          if (out_alloc_start !== want_start_q[0])
            report($sformatf("alloc_start got %0d want %0d",
                             out_alloc_start, want_start_q[0]));
          void'(want_status_q.pop_front());
          void'(want_start_q.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        base = '0;
        if (in_op == vpa_pkg::OP_ALLOC) st = place_job(in_job_id, int'(in_req_size), base);
        else st = free_job(in_job_id);
        if (st != vpa_pkg::ST_OK) base = '0;
        if (st == vpa_pkg::ST_FULL) full_hits++;
        want_status_q.push_back(st);
        want_start_q.push_back(base);
      end
    end
  end

  always @(posedge end_check) begin
    while (want_status_q.size() > 0) begin
      report($sformatf("result never came, status %0d", want_status_q[0]));
      void'(want_status_q.pop_front());
    end
  end
endmodule

[verif/tb_variable_partition_allocator_core.sv]
// Testbench top: stimulus, handshake pacing and verdict for the partition allocator.
module tb_variable_partition_allocator_core;
  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [vpa_pkg::POL_W-1:0]       cfg_fit_policy;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_op;
  logic [vpa_pkg::IN_JOB_W-1:0]    in_job_id;
  logic [vpa_pkg::REQ_W-1:0]       in_req_size;
  logic                            out_valid;
  logic                            out_stall;
  logic [vpa_pkg::STATUS_W-1:0]    out_status;
  logic [vpa_pkg::START_O_W-1:0]   out_alloc_start;
  logic                            end_check;

  int fail_count, checked, full_hits;
  int sent_count, taken_count, done_count;
  int idle_pct;       // chance in percent of an idle burst before a transaction
  bit hold_req;       // ask the receiver for one long hold-off
  logic [15:0] jobs [8];

  variable_partition_allocator_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_fit_policy(cfg_fit_policy),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_job_id(in_job_id), .in_req_size(in_req_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_alloc_start(out_alloc_start)
  );

  vpa_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_fit_policy(cfg_fit_policy),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_job_id(in_job_id), .in_req_size(in_req_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_alloc_start(out_alloc_start),
    .end_check(end_check),
    .fail_count(fail_count), .checked(checked), .full_hits(full_hits)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Count transactions on both channels so that phases can wait for the block to drain.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) taken_count <= taken_count + 1;
    if (rst_n && out_valid && !out_stall) done_count <= done_count + 1;
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block parks a result, takes one more transaction and then stalls its input.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one transaction; hold the payload until it is taken.
  task automatic send(input logic op, input logic [15:0] job, input logic [9:0] size);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_job_id   <= job;
    in_req_size <= size;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Drop valid, wait for every result, then let the block finish any trailing work.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (done_count != taken_count) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic set_policy(input vpa_pkg::policy_t pol);
    cfg_we         <= 1'b1;
    cfg_fit_policy <= pol;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Size mix: mostly small so the table fills, some mid, a few anywhere in the field.
  function automatic logic [9:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 10'($urandom_range(1, 24));
    if (r < 95) return 10'($urandom_range(25, 200));
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic random_phase(input int n_items);
    int done;
    int r;
    done = 0;
    jobs[0] = 16'h0000;
    jobs[1] = 16'hFFFF;
    for (int k = 2; k < 8; k++) jobs[k] = 16'($urandom);
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // fill burst: many tiny allocations to push the table to its limit, then free all
        repeat ($urandom_range(20, 70)) begin
          send(vpa_pkg::OP_ALLOC, jobs[$urandom_range(0, 7)], 10'($urandom_range(1, 3)));
          done++;
        end
        for (int k = 0; k < 8; k++) begin
          send(vpa_pkg::OP_RELEASE, jobs[k], pick_size());
          done++;
        end
      end else if (r < 62) begin
        send(vpa_pkg::OP_ALLOC, jobs[$urandom_range(0, 7)], pick_size());
        done++;
      end else if (r < 95) begin
        send(vpa_pkg::OP_RELEASE, jobs[$urandom_range(0, 7)], 10'($urandom));
        done++;
      end else begin
        send(r[0] ? vpa_pkg::OP_RELEASE : vpa_pkg::OP_ALLOC, 16'($urandom), pick_size());
        done++;
      end
    end
  endtask

  initial begin
    vpa_pkg::policy_t plan [8];
    plan = '{vpa_pkg::POL_BEST, vpa_pkg::POL_WORST, vpa_pkg::policy_t'(3),
             vpa_pkg::POL_FIRST, vpa_pkg::POL_WORST, vpa_pkg::POL_BEST,
             vpa_pkg::POL_FIRST, vpa_pkg::POL_WORST};
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_fit_policy <= vpa_pkg::POL_FIRST;
    in_valid       <= 1'b0;
    in_op          <= vpa_pkg::OP_ALLOC;
    in_job_id      <= '0;
    in_req_size    <= '0;
    end_check      <= 1'b0;
    hold_req = 0;
    idle_pct = 20;
    sent_count = 0;
    taken_count = 0;
    done_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_policy(vpa_pkg::POL_FIRST);

    // Directed: rejects, exact fit over the whole memory, splits and merges.
    send(vpa_pkg::OP_ALLOC,   16'd1,     10'd0);      // zero size is rejected
    send(vpa_pkg::OP_ALLOC,   16'd1,     10'd1023);   // larger than memory
    send(vpa_pkg::OP_ALLOC,   16'd1,     10'd513);
    send(vpa_pkg::OP_RELEASE, 16'd7,     10'd0);      // job with nothing allocated
    send(vpa_pkg::OP_ALLOC,   16'hFFFF,  10'd512);    // exact fit, no remainder entry
    send(vpa_pkg::OP_ALLOC,   16'd2,     10'd1);      // memory exhausted
    send(vpa_pkg::OP_RELEASE, 16'hFFFF,  10'd1023);
    send(vpa_pkg::OP_ALLOC,   16'h0000,  10'd100);
    send(vpa_pkg::OP_ALLOC,   16'h5555,  10'd1);
    send(vpa_pkg::OP_ALLOC,   16'hAAAA,  10'd200);
    send(vpa_pkg::OP_ALLOC,   16'h0000,  10'd50);
    send(vpa_pkg::OP_RELEASE, 16'h0000,  10'd0);      // two holes, one merges with the tail
    send(vpa_pkg::OP_ALLOC,   16'd1,     10'd100);    // exact fit into the first hole
    send(vpa_pkg::OP_ALLOC,   16'd1,     10'd30);
    send(vpa_pkg::OP_RELEASE, 16'h5555,  10'd0);
    send(vpa_pkg::OP_RELEASE, 16'hAAAA,  10'd0);
    send(vpa_pkg::OP_RELEASE, 16'd1,     10'd0);      // everything merges back into one
    send(vpa_pkg::OP_ALLOC,   16'd3,     10'd10);
    send(vpa_pkg::OP_ALLOC,   16'd4,     10'd10);
    send(vpa_pkg::OP_RELEASE, 16'd3,     10'd0);
    send(vpa_pkg::OP_ALLOC,   16'd5,     10'd5);
    send(vpa_pkg::OP_RELEASE, 16'd4,     10'd0);      // free on both sides
    send(vpa_pkg::OP_RELEASE, 16'd5,     10'd0);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_policy(plan[p]);
      idle_pct = (p == 3) ? 0 : 20;         // phase three runs with no idling at all
      if (p == 7) idle_pct = 0;             // quiet tail
      if (p == 1) begin
        fork
          random_phase(200);
          begin
            repeat (300) @(posedge clk);
            hold_req = 1;
          end
        join
      end else begin
        random_phase(200);
      end
      drain();
    end

    end_check <= 1'b1;
    repeat (3) @(posedge clk);
    $display("Ran %0d transactions over first, best, worst fit and policy three;",
             sent_count);
    $display("%0d results checked, %0d table-full rejects seen.", checked, full_hits);
    if (fail_count == 0) begin
      $display("variable_partition_allocator_core verification clean");
    end else begin
      $display("variable_partition_allocator_core verification failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Timeout with %0d transactions sent.", sent_count);
    $display("variable_partition_allocator_core verification failed");
    $finish;
  end
endmodule
